FILE: hw/rtl/pcfa_pkg.sv
package pcfa_pkg;

  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_NUM_W = 32 - PAGE_SHIFT;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd1;
  localparam logic [1:0] STATUS_NO_MEM   = 2'd2;

  localparam logic REG_REGION_START = 1'b0;
  localparam logic REG_REGION_END   = 1'b1;

  localparam logic [31:0] REGION_START_RESET = 32'h8000_0000;
  localparam logic [31:0] REGION_END_RESET   = 32'h8800_0000;

endpackage

FILE: hw/rtl/pcfa_link_mem.sv
module pcfa_link_mem #(
  parameter int DEPTH = 32768,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/pcfa_addr_check.sv
module pcfa_addr_check #(
  parameter int MAX_PAGES = 32768
) (
  input  logic                         clk,
  input  logic [31:0]                  address,
  input  logic [31:0]                  region_start,
  input  logic [31:0]                  region_end,
  output logic                         bad,
  output logic [$clog2(MAX_PAGES)-1:0] idx
);

  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam int PNW   = pcfa_pkg::PAGE_NUM_W;
  localparam logic [PNW:0] PAGE_LIMIT = (PNW + 1)'(MAX_PAGES);

  logic [PNW-1:0] page_diff;
  logic           misaligned;
  logic           below;
  logic           above;
  logic           too_far;

  // The address is at or above region_start whenever the index is used, so the
  // page difference cannot wrap.
  assign page_diff  = address[31:pcfa_pkg::PAGE_SHIFT] -
                      region_start[31:pcfa_pkg::PAGE_SHIFT];
  assign misaligned = |address[pcfa_pkg::PAGE_SHIFT-1:0];
  assign below      = address < region_start;
  assign above      = address >= region_end;
  assign too_far    = {1'b0, page_diff} >= PAGE_LIMIT;

  always_ff @(posedge clk) begin
    bad <= misaligned | below | above | too_far;
    idx <= page_diff[IDX_W-1:0];
  end

endmodule

FILE: hw/rtl/per_cpu_page_free_list_allocator_top.sv
// Channel    Direction  Ports                         Handshake
// command    in         command, cpu, address         start high, busy low
// result     out        status, page_address          done, one cycle, no stall
// config     in         cfg_index, cfg_data           cfg_write, no wait
//
// A free or a successful allocate goes from the accepting edge to the edge that
// takes the result in steps: free is latch, address check, link write;
// allocate is latch, head select with link read, link data return.
// With every list empty an allocate needs no link read and ends at head select.
// The next request can be accepted while done is high.
// Reset empties every list at once; the link memory needs no clearing.
// Results cannot be stalled, so done is a single-cycle strobe.
module per_cpu_page_free_list_allocator_top #(
  parameter int NUM_CPUS  = 8,
  parameter int MAX_PAGES = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [2:0]  cpu,
  input  logic [31:0] address,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] page_address,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W  = $clog2(MAX_PAGES);
  localparam int LINK_W = IDX_W + 1;
  localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int PNW    = pcfa_pkg::PAGE_NUM_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FREE,
    S_ALLOC_SEL,
    S_ALLOC_RD
  } state_t;

  state_t state;

  logic [31:0]      region_start;
  logic [31:0]      region_end;
  logic [31:0]      req_address;
  logic [CPU_W-1:0] req_cpu;
  logic [CPU_W-1:0] sel_cpu;
  logic [IDX_W-1:0] sel_idx;

  logic [IDX_W-1:0]    head [NUM_CPUS];
  logic [NUM_CPUS-1:0] head_ok;

  logic             chk_bad;
  logic [IDX_W-1:0] chk_idx;

  logic             mem_we;
  logic             mem_re;
  logic [LINK_W-1:0] mem_wdata;
  logic [LINK_W-1:0] mem_rdata;

  logic [CPU_W-1:0] cpu_wrapped;
  logic [CPU_W-1:0] first_cpu;
  logic [CPU_W-1:0] pick_cpu;
  logic             any_ok;
  logic [PNW-1:0]   out_page;

  function automatic logic [4:0] wrap_cpu(input logic [2:0] c);
    logic [4:0] v;
    v = {2'b00, c};
    for (int i = 0; i < 8; i++) begin
      if (v >= 5'(NUM_CPUS)) begin
        v = v - 5'(NUM_CPUS);
      end
    end
    return v;
  endfunction

  assign cpu_wrapped = CPU_W'(wrap_cpu(cpu));

  // The requesting CPU's list comes first; otherwise the lowest non-empty one.
  always_comb begin
    first_cpu = '0;
    for (int i = NUM_CPUS - 1; i >= 0; i--) begin
      if (head_ok[i]) begin
        first_cpu = CPU_W'(i);
      end
    end
  end

  assign any_ok   = |head_ok;
  assign pick_cpu = head_ok[req_cpu] ? req_cpu : first_cpu;
  assign busy     = state != S_IDLE;

  assign mem_we    = (state == S_FREE) && !chk_bad;
  assign mem_wdata = {head_ok[req_cpu], head[req_cpu]};
  assign mem_re    = (state == S_ALLOC_SEL) && any_ok;
  assign out_page  = region_start[31:pcfa_pkg::PAGE_SHIFT] + PNW'(sel_idx);

  pcfa_addr_check #(
    .MAX_PAGES(MAX_PAGES)
  ) u_check (
    .clk         (clk),
    .address     (req_address),
    .region_start(region_start),
    .region_end  (region_end),
    .bad         (chk_bad),
    .idx         (chk_idx)
  );

  pcfa_link_mem #(
    .DEPTH(MAX_PAGES),
    .WIDTH(LINK_W)
  ) u_links (
    .clk  (clk),
    .we   (mem_we),
    .waddr(chk_idx),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(head[pick_cpu]),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= pcfa_pkg::REGION_START_RESET;
      region_end   <= pcfa_pkg::REGION_END_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        pcfa_pkg::REG_REGION_START: region_start <= cfg_data;
        pcfa_pkg::REG_REGION_END:   region_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      head_ok <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_cpu     <= cpu_wrapped;
            req_address <= address;
            state       <= (command == pcfa_pkg::CMD_FREE) ? S_CHECK : S_ALLOC_SEL;
          end
        end
        S_CHECK: begin
          state <= S_FREE;
        end
        S_FREE: begin
          done         <= 1'b1;
          page_address <= '0;
          if (chk_bad) begin
            status <= pcfa_pkg::STATUS_BAD_FREE;
          end else begin
            status           <= pcfa_pkg::STATUS_OK;
            head[req_cpu]    <= chk_idx;
            head_ok[req_cpu] <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_ALLOC_SEL: begin
          sel_cpu <= pick_cpu;
          sel_idx <= head[pick_cpu];
          if (any_ok) begin
            state <= S_ALLOC_RD;
          end else begin
            done         <= 1'b1;
            status       <= pcfa_pkg::STATUS_NO_MEM;
            page_address <= '0;
            state        <= S_IDLE;
          end
        end
        S_ALLOC_RD: begin
          head[sel_cpu]    <= mem_rdata[IDX_W-1:0];
          head_ok[sel_cpu] <= mem_rdata[IDX_W];
          done             <= 1'b1;
          status           <= pcfa_pkg::STATUS_OK;
          page_address     <= {out_page, {pcfa_pkg::PAGE_SHIFT{1'b0}}};
          state            <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FREE || state == S_ALLOC_SEL || state == S_ALLOC_RD))
    else $error("result strobe without a finishing step");

  a_no_mem_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == pcfa_pkg::STATUS_NO_MEM) |-> (head_ok == '0))
    else $error("out of memory reported while a list holds pages");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != pcfa_pkg::STATUS_OK) |-> (page_address == '0))
    else $error("failed request returned a nonzero address");

  a_read_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC_RD) |-> $past(state == S_ALLOC_SEL))
    else $error("link data used without a read");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start");

endmodule
